[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file, ial_checker.sv.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define IAL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted during reset.
`define IAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ial_pkg.sv]
// Shared types for the indexed array list: opcodes, status codes, beat structs,
// and the command/status bundles between controller and datapath. No dependencies.
package ial_pkg;

  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5,
    OP_RESIZE = 3'd6,
    OP_CLEAR  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_data;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } rsp_t;

  // Write address/data source
  typedef enum logic [2:0] {
    WR_PUSH = 3'd0,  // mem[count] <= value
    WR_POS  = 3'd1,  // mem[pos]   <= value
    WR_UP   = 3'd2,  // mem[idx+1] <= rdata
    WR_DN   = 3'd3,  // mem[idx-1] <= rdata
    WR_FILL = 3'd4   // mem[idx]   <= value
  } wsel_t;

  typedef enum logic [2:0] {
    IDX_HOLD     = 3'd0,
    IDX_TOP      = 3'd1,  // count - 1
    IDX_NEXT_POS = 3'd2,  // pos + 1
    IDX_COUNT    = 3'd3,
    IDX_INC      = 3'd4,
    IDX_DEC      = 3'd5
  } idx_cmd_t;

  typedef enum logic [2:0] {
    CNT_HOLD = 3'd0,
    CNT_INC  = 3'd1,
    CNT_DEC  = 3'd2,
    CNT_POS  = 3'd3,
    CNT_ZERO = 3'd4
  } cnt_cmd_t;

  typedef struct packed {
    logic     capture;
    logic     decode;
    logic     rd_en;
    logic     rd_at_pos;
    logic     wr_en;
    wsel_t    wsel;
    idx_cmd_t idx_cmd;
    cnt_cmd_t cnt_cmd;
    logic     load_rsp;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ok;
    logic count_nz;
    logic pos_eq_count;
    logic pos_eq_last;
    logic pos_gt_count;
    logic idx_eq_pos;
    logic idx_eq_last;
    logic idx_eq_pos_m1;
  } ctl_sts_t;

endpackage

[hw/rtl/ial_ctrl.sv]
// Sequencer for the indexed array list: one-hot FSM driving the datapath.
// Depends on ial_pkg.
module ial_ctrl import ial_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_UP_RD  = 9'b000000100,
    S_UP_WR  = 9'b000001000,
    S_UP_INS = 9'b000010000,
    S_DN_RD  = 9'b000100000,
    S_DN_WR  = 9'b001000000,
    S_FILL   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_FINISH;
        if (sts.ok) begin
          case (sts.op)
            OP_PUSH: begin
              cmd.wr_en   = 1'b1;
              cmd.wsel    = WR_PUSH;
              cmd.cnt_cmd = CNT_INC;
            end
            OP_POP: begin
              if (sts.count_nz) begin
                cmd.cnt_cmd = CNT_DEC;
              end
            end
            OP_INSERT: begin
              if (sts.pos_eq_count) begin
                cmd.wr_en   = 1'b1;
                cmd.wsel    = WR_POS;
                cmd.cnt_cmd = CNT_INC;
              end else begin
                cmd.idx_cmd = IDX_TOP;
                state_next  = S_UP_RD;
              end
            end
            OP_ERASE: begin
              if (sts.pos_eq_last) begin
                cmd.cnt_cmd = CNT_DEC;
              end else begin
                cmd.idx_cmd = IDX_NEXT_POS;
                state_next  = S_DN_RD;
              end
            end
            OP_READ: begin
              cmd.rd_en     = 1'b1;
              cmd.rd_at_pos = 1'b1;
            end
            OP_WRITE: begin
              cmd.wr_en = 1'b1;
              cmd.wsel  = WR_POS;
            end
            OP_RESIZE: begin
              if (sts.pos_gt_count) begin
                cmd.idx_cmd = IDX_COUNT;
                state_next  = S_FILL;
              end else begin
                cmd.cnt_cmd = CNT_POS;
              end
            end
            OP_CLEAR: begin
              cmd.cnt_cmd = CNT_ZERO;
            end
            default: begin
              cmd.cnt_cmd = CNT_HOLD;
            end
          endcase
        end
      end
      S_UP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_UP_WR;
      end
      S_UP_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WR_UP;
        if (sts.idx_eq_pos) begin
          state_next = S_UP_INS;
        end else begin
          cmd.idx_cmd = IDX_DEC;
          state_next  = S_UP_RD;
        end
      end
      S_UP_INS: begin
        cmd.wr_en   = 1'b1;
        cmd.wsel    = WR_POS;
        cmd.cnt_cmd = CNT_INC;
        state_next  = S_FINISH;
      end
      S_DN_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DN_WR;
      end
      S_DN_WR: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WR_DN;
        if (sts.idx_eq_last) begin
          cmd.cnt_cmd = CNT_DEC;
          state_next  = S_FINISH;
        end else begin
          cmd.idx_cmd = IDX_INC;
          state_next  = S_DN_RD;
        end
      end
      S_FILL: begin
        cmd.wr_en = 1'b1;
        cmd.wsel  = WR_FILL;
        if (sts.idx_eq_pos_m1) begin
          cmd.cnt_cmd = CNT_POS;
          state_next  = S_FINISH;
        end else begin
          cmd.idx_cmd = IDX_INC;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/ial_datapath.sv]
// Datapath for the indexed array list: element memory, count, walk index,
// status decode and the result register. Depends on ial_pkg.
module ial_datapath import ial_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  input  ctl_cmd_t cmd,
  output ctl_sts_t sts,
  output rsp_t     rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int VW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  op_t                   op;
  logic [POS_W-1:0]      pos;
  logic [DATA_WIDTH-1:0] val;
  status_t               st;
  status_t               st_calc;
  logic [CW-1:0]         count;
  logic [IW-1:0]         idx;
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata;

  logic [XW-1:0]         pos_x, cnt_x, idx_x, last_x, cap_x;
  logic [VW-1:0]         in_val_x, rd_x;
  logic [IW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata;

  assign pos_x    = XW'(pos);
  assign cnt_x    = XW'(count);
  assign idx_x    = XW'(idx);
  assign last_x   = cnt_x - XW'(1);
  assign cap_x    = XW'(CAPACITY);
  assign in_val_x = VW'(req.value);
  assign rd_x     = VW'(rdata);

  always_comb begin
    st_calc = ST_OK;
    case (op)
      OP_PUSH:   if (cnt_x >= cap_x) st_calc = ST_FULL;
      OP_POP:    st_calc = ST_OK;
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          st_calc = ST_RANGE;
        end else if (cnt_x >= cap_x) begin
          st_calc = ST_FULL;
        end
      end
      OP_ERASE, OP_READ, OP_WRITE: if (pos_x >= cnt_x) st_calc = ST_RANGE;
      OP_RESIZE: if (pos_x > cap_x) st_calc = ST_FULL;
      OP_CLEAR:  st_calc = ST_OK;
      default:   st_calc = ST_OK;
    endcase
  end

  assign sts.op            = op;
  assign sts.ok            = (st_calc == ST_OK);
  assign sts.count_nz      = (count != '0);
  assign sts.pos_eq_count  = (pos_x == cnt_x);
  assign sts.pos_eq_last   = (pos_x == last_x);
  assign sts.pos_gt_count  = (pos_x > cnt_x);
  assign sts.idx_eq_pos    = (idx_x == pos_x);
  assign sts.idx_eq_last   = (idx_x == last_x);
  assign sts.idx_eq_pos_m1 = (idx_x == (pos_x - XW'(1)));

  always_comb begin
    case (cmd.wsel)
      WR_PUSH: begin
        waddr = count[IW-1:0];
        wdata = val;
      end
      WR_POS: begin
        waddr = pos_x[IW-1:0];
        wdata = val;
      end
      WR_UP: begin
        waddr = idx + IW'(1);
        wdata = rdata;
      end
      WR_DN: begin
        waddr = idx - IW'(1);
        wdata = rdata;
      end
      WR_FILL: begin
        waddr = idx;
        wdata = val;
      end
      default: begin
        waddr = idx;
        wdata = val;
      end
    endcase
  end

  assign raddr = cmd.rd_at_pos ? pos_x[IW-1:0] : idx;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= req.operation;
      pos <= req.position;
      val <= in_val_x[DATA_WIDTH-1:0];
    end
    if (cmd.decode) begin
      st <= st_calc;
    end
    case (cmd.idx_cmd)
      IDX_TOP:      idx <= last_x[IW-1:0];
      IDX_NEXT_POS: idx <= pos_x[IW-1:0] + IW'(1);
      IDX_COUNT:    idx <= count[IW-1:0];
      IDX_INC:      idx <= idx + IW'(1);
      IDX_DEC:      idx <= idx - IW'(1);
      default:      idx <= idx;
    endcase
    if (cmd.load_rsp) begin
      rsp.read_data <= (op == OP_READ && st == ST_OK) ? rd_x[VALUE_W-1:0] : '0;
      rsp.status    <= st;
      rsp.count     <= cnt_x[COUNT_W-1:0];
      rsp.is_empty  <= (count == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_cmd)
        CNT_INC:  count <= count + CW'(1);
        CNT_DEC:  count <= count - CW'(1);
        CNT_POS:  count <= pos_x[CW-1:0];
        CNT_ZERO: count <= '0;
        default:  count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/indexed_array_list.sv]
// Indexed array list: one response beat per request beat, one op in flight at a time.
// Every op is captured in idle, decoded, then answered from the finish state, which waits for
// rsp_ready while an older response is still held. Insert below count first walks entries up from
// the top and then writes at pos; erase walks entries down from pos+1; grow resize fills with value.
// Shifts move one entry per read/write pair on the single-port element memory.
// Reset (rst, synchronous) empties the list and drops any pending response.
module indexed_array_list import ial_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ial_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ial_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

[hw/rtl/ial_checker.sv]
// Port-level checks for indexed_array_list, bound to the top level.
// Depends on ial_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ial_checker import ial_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  `IAL_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req), "req beat changed")
  `IAL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp beat changed")
  `IAL_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "req taken while busy")
  `IAL_ASSERT_IMPL(a_empty_count, rsp_valid && rsp.is_empty, rsp.count == '0, "empty with count")
  `IAL_ASSERT_IMPL(a_rd_zero_on_err, rsp_valid && rsp.status != ST_OK, rsp.read_data == '0, "rd on err")

endmodule

bind indexed_array_list ial_checker u_ial_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

[verif/indexed_array_list_test.sv]
// Self-checking testbench for indexed_array_list: directed table, then random
// list operations. Depends on ial_pkg and the indexed_array_list RTL.
module indexed_array_list_test;
  import ial_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP = 16;
  localparam int RANDOM_OPS = 2000;
  localparam int PAUSE_AT = 1200;    // sender drains all results here
  localparam int HOLD_AT = 700;      // receiver stalls after this many beats
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    req_t    stim;
    bit      typed;
    rsp_t    want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  indexed_array_list dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  // Shadow copy of the list
  logic [VALUE_W-1:0] list_mem [0:LIST_CAP-1];
  int list_len;

  rsp_t awaited_results [$];
  dir_row_t dir_plan [$];
  int mismatches;
  int results_seen;
  bit src_burst;
  bit sink_burst;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Applies one operation to the shadow list and returns its result beat.
  function automatic rsp_t list_apply(req_t r);
    rsp_t o;
    int p;
    o = '0;
    o.status = ST_OK;
    p = int'(r.position);
    case (r.operation)
      OP_PUSH: begin
        if (list_len >= LIST_CAP) o.status = ST_FULL;
        else begin
          list_mem[list_len] = r.value;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len > 0) list_len--;
      end
      OP_INSERT: begin
        // out-of-range wins over full
        if (p > list_len) o.status = ST_RANGE;
        else if (list_len >= LIST_CAP) o.status = ST_FULL;
        else begin
          for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = r.value;
          list_len++;
        end
      end
      OP_ERASE: begin
        if (p >= list_len) o.status = ST_RANGE;
        else begin
          for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (p >= list_len) o.status = ST_RANGE;
        else o.read_data = list_mem[p];
      end
      OP_WRITE: begin
        if (p >= list_len) o.status = ST_RANGE;
        else list_mem[p] = r.value;
      end
      OP_RESIZE: begin
        if (p > LIST_CAP) o.status = ST_FULL;
        else begin
          for (int i = list_len; i < p; i++) list_mem[i] = r.value;
          list_len = p;
        end
      end
      default: list_len = 0;
    endcase
    o.count = COUNT_W'(list_len);
    o.is_empty = (list_len == 0);
    return o;
  endfunction

  function automatic dir_row_t row(op_t op, int pos, logic [VALUE_W-1:0] val, bit typed,
                                   logic [VALUE_W-1:0] rd, status_t st, int cnt);
    dir_row_t d;
    d.stim.operation = op;
    d.stim.position = POS_W'(pos);
    d.stim.value = val;
    d.typed = typed;
    d.want.read_data = rd;
    d.want.status = st;
    d.want.count = COUNT_W'(cnt);
    d.want.is_empty = (cnt == 0);
    return d;
  endfunction

  // Mostly well-formed operations against the current list, some noise.
  function automatic req_t pick_op();
    req_t r;
    int w;
    int cnt;
    cnt = list_len;
    w = $urandom_range(0, 99);
    if (w < 18) r.operation = OP_PUSH;
    else if (w < 28) r.operation = OP_POP;
    else if (w < 44) r.operation = OP_INSERT;
    else if (w < 56) r.operation = OP_ERASE;
    else if (w < 72) r.operation = OP_READ;
    else if (w < 84) r.operation = OP_WRITE;
    else if (w < 97) r.operation = OP_RESIZE;
    else r.operation = OP_CLEAR;
    case ($urandom_range(0, 7))
      0: r.value = '0;
      1: r.value = '1;
      default: r.value = $urandom();
    endcase
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 19) == 0) r.position = POS_W'($urandom_range(17, 31));
      else r.position = POS_W'($urandom_range(0, 16));
    end else begin
      case (r.operation)
        OP_INSERT: r.position = POS_W'($urandom_range(0, cnt));
        OP_ERASE, OP_READ, OP_WRITE:
          r.position = (cnt > 0) ? POS_W'($urandom_range(0, cnt - 1)) : '0;
        default: r.position = POS_W'($urandom_range(0, LIST_CAP));
      endcase
    end
    return r;
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 19));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_op(req_t item, bit typed, rsp_t want);
    int gap;
    rsp_t pred;
    gap = draw_gap(src_burst);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pred = list_apply(item);
    if (typed) pred = want;
    awaited_results = {awaited_results, pred};
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    list_len = 0;
    mismatches = 0;
    results_seen = 0;
    src_burst = 1'b0;
    sink_burst = 1'b0;
    for (int i = 0; i < LIST_CAP; i++) list_mem[i] = '0;

    dir_plan = {dir_plan, row(OP_READ,    0,  32'h0,         1, 32'h0,         ST_RANGE, 0)};
    dir_plan = {dir_plan, row(OP_POP,     0,  32'h0,         1, 32'h0,         ST_OK,    0)};
    dir_plan = {dir_plan, row(OP_ERASE,   0,  32'h0,         1, 32'h0,         ST_RANGE, 0)};
    dir_plan = {dir_plan, row(OP_WRITE,   0,  32'h1234_5678, 1, 32'h0,         ST_RANGE, 0)};
    dir_plan = {dir_plan, row(OP_INSERT,  1,  32'h1,         1, 32'h0,         ST_RANGE, 0)};
    dir_plan = {dir_plan, row(OP_INSERT,  0,  32'hFFFF_FFFF, 1, 32'h0,         ST_OK,    1)};
    dir_plan = {dir_plan, row(OP_PUSH,    0,  32'h0,         1, 32'h0,         ST_OK,    2)};
    dir_plan = {dir_plan, row(OP_READ,    0,  32'h0,         1, 32'hFFFF_FFFF, ST_OK,    2)};
    dir_plan = {dir_plan, row(OP_READ,    1,  32'h0,         1, 32'h0,         ST_OK,    2)};
    dir_plan = {dir_plan, row(OP_RESIZE,  16, 32'hA5A5_A5A5, 1, 32'h0,         ST_OK,    16)};
    dir_plan = {dir_plan, row(OP_PUSH,    0,  32'h7,         1, 32'h0,         ST_FULL,  16)};
    dir_plan = {dir_plan, row(OP_INSERT,  16, 32'h7,         1, 32'h0,         ST_FULL,  16)};
    dir_plan = {dir_plan, row(OP_INSERT,  31, 32'h7,         1, 32'h0,         ST_RANGE, 16)};
    dir_plan = {dir_plan, row(OP_READ,    15, 32'h0,         1, 32'hA5A5_A5A5, ST_OK,    16)};
    dir_plan = {dir_plan, row(OP_READ,    16, 32'h0,         1, 32'h0,         ST_RANGE, 16)};
    dir_plan = {dir_plan, row(OP_WRITE,   15, 32'h5A5A_5A5A, 0, '0, ST_OK, 0)};
    dir_plan = {dir_plan, row(OP_ERASE,   0,  32'h0,         0, '0, ST_OK, 0)};
    dir_plan = {dir_plan, row(OP_INSERT,  5,  32'h1234_5678, 0, '0, ST_OK, 0)};
    dir_plan = {dir_plan, row(OP_ERASE,   15, 32'h0,         0, '0, ST_OK, 0)};
    dir_plan = {dir_plan, row(OP_RESIZE,  17, 32'h3,         1, 32'h0,         ST_FULL,  15)};
    dir_plan = {dir_plan, row(OP_RESIZE,  4,  32'h9,         0, '0, ST_OK, 0)};
    dir_plan = {dir_plan, row(OP_RESIZE,  8,  32'h0,         0, '0, ST_OK, 0)};
    dir_plan = {dir_plan, row(OP_READ,    7,  32'h0,         0, '0, ST_OK, 0)};
    dir_plan = {dir_plan, row(OP_READ,    3,  32'h0,         0, '0, ST_OK, 0)};
    dir_plan = {dir_plan, row(OP_CLEAR,   0,  32'h0,         1, 32'h0,         ST_OK,    0)};

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_plan[k]) send_op(dir_plan[k].stim, dir_plan[k].typed, dir_plan[k].want);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 50 == 0) src_burst = ($urandom_range(0, 3) == 0);
      if (n == PAUSE_AT) begin
        req_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      send_op(pick_op(), 1'b0, '0);
    end
    req_valid <= 1'b0;

    while (awaited_results.size() != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Result side: random stalls plus one long hold-off
  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (results_seen % 50 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      gap = draw_gap(sink_burst);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
      if (results_seen == HOLD_AT) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: %p", rsp);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
          mismatches++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          mismatches++;
        end
        if (rsp.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp.count);
          mismatches++;
        end
        if (rsp.is_empty !== want.is_empty) begin
          $error("is_empty: expected %b, got %b", want.is_empty, rsp.is_empty);
          mismatches++;
        end
      end
    end
  end

endmodule
